>>> sv/sfvp_pkg.sv
`default_nettype none
package sfvp_pkg;

  // Fixed-point format and line store geometry.
  localparam int FRACTION_BITS = 16;
  localparam int MAX_COLUMNS   = 256;
  localparam int COL_W         = $clog2(MAX_COLUMNS);
  localparam int ADDR_W        = COL_W + 1;
  localparam int LINE_DEPTH    = 2 * MAX_COLUMNS;

  localparam int DATA_W = 32;
  localparam int COLS_W = 9;
  localparam int ROWS_W = 16;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CFG_GRID_COLUMNS = 2'd0,
    CFG_GRID_ROWS    = 2'd1,
    CFG_FREE_STREAM  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] stream_value;
    logic signed [DATA_W-1:0] x_pos;
    logic signed [DATA_W-1:0] y_pos;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] u_vel;
    logic signed [DATA_W-1:0] v_vel;
    logic signed [DATA_W-1:0] pressure;
    logic [COL_W-1:0]         cell_col;
    logic [ROWS_W-1:0]        cell_row;
    logic                     div_fault;
    logic                     frame_end;
  } out_res_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] psi;
    logic signed [DATA_W-1:0] xc;
    logic signed [DATA_W-1:0] yc;
  } line_word_t;

endpackage
`default_nettype wire

>>> sv/sfvp_lines.sv
`default_nettype none
module sfvp_lines (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [sfvp_pkg::ADDR_W-1:0]  waddr_i,
  input  wire sfvp_pkg::line_word_t         wdata_i,
  input  wire logic [sfvp_pkg::ADDR_W-1:0]  raddr_i,
  output sfvp_pkg::line_word_t              rdata_o
);

  // Two rows per store; the row parity selects the half.
  logic signed [sfvp_pkg::DATA_W-1:0] psi_mem [sfvp_pkg::LINE_DEPTH];
  logic signed [sfvp_pkg::DATA_W-1:0] x_mem   [sfvp_pkg::LINE_DEPTH];
  logic signed [sfvp_pkg::DATA_W-1:0] y_mem   [sfvp_pkg::LINE_DEPTH];
  sfvp_pkg::line_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      psi_mem[waddr_i] <= wdata_i.psi;
      x_mem[waddr_i]   <= wdata_i.xc;
      y_mem[waddr_i]   <= wdata_i.yc;
    end
    rdata_q.psi <= psi_mem[raddr_i];
    rdata_q.xc  <= x_mem[raddr_i];
    rdata_q.yc  <= y_mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/sfvp_div.sv
`default_nettype none
module sfvp_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [sfvp_pkg::DATA_W:0]  num_i,
  input  wire logic signed [sfvp_pkg::DATA_W:0]  den_i,
  output logic                                   done_o,
  output logic signed [sfvp_pkg::DATA_W-1:0]     quo_o,
  output logic                                   fault_o
);

  localparam int NW = sfvp_pkg::DATA_W + 1;
  localparam int DW = NW + sfvp_pkg::FRACTION_BITS;
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] POS_LIM = DW'(33'h0_7FFF_FFFF);
  localparam logic [DW-1:0] NEG_LIM = DW'(33'h0_8000_0000);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] rem_q, den_q;
  logic [DW-1:0] quo_q;
  logic          neg_q, zero_q, nsign_q, nzero_q;

  logic [NW-1:0] num_abs, den_abs;
  logic [NW:0]   trial, diff;

  assign num_abs = num_i[NW-1] ? (~num_i + NW'(1)) : num_i;
  assign den_abs = den_i[NW-1] ? (~den_i + NW'(1)) : den_i;
  assign trial   = {rem_q, quo_q[DW-1]};
  assign diff    = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // Restoring division of magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q   <= {num_abs, {sfvp_pkg::FRACTION_BITS{1'b0}}};
      rem_q   <= '0;
      den_q   <= den_abs;
      neg_q   <= num_i[NW-1] ^ den_i[NW-1];
      zero_q  <= (den_i == '0);
      nsign_q <= num_i[NW-1];
      nzero_q <= (num_i != '0);
    end else if (busy_q) begin
      if (!diff[NW]) begin
        rem_q <= diff[NW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= trial[NW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (zero_q) begin
      if (!nzero_q) begin
        quo_o = '0;
      end else begin
        quo_o = nsign_q ? sfvp_pkg::S32_MIN : sfvp_pkg::S32_MAX;
      end
    end else if (neg_q) begin
      quo_o = (quo_q > NEG_LIM) ? sfvp_pkg::S32_MIN : -$signed(quo_q[31:0]);
    end else begin
      quo_o = (quo_q > POS_LIM) ? sfvp_pkg::S32_MAX : $signed(quo_q[31:0]);
    end
  end

  assign done_o  = done_q;
  assign fault_o = zero_q;

endmodule
`default_nettype wire

>>> sv/sfvp_press.sv
`default_nettype none
module sfvp_press (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [sfvp_pkg::DATA_W-1:0] speed_i,
  input  wire logic signed [sfvp_pkg::DATA_W-1:0] u_i,
  input  wire logic signed [sfvp_pkg::DATA_W-1:0] v_i,
  output logic                                   done_o,
  output logic signed [sfvp_pkg::DATA_W-1:0]     pressure_o
);

  localparam int PW = 2 * sfvp_pkg::DATA_W;
  localparam int AW = PW + 2;
  localparam logic signed [AW-1:0] P_MAX = AW'(64'sh7FFF_FFFF);
  localparam logic signed [AW-1:0] P_MIN = -AW'(64'sh8000_0000);

  logic                 busy_q, done_q;
  logic [1:0]           step_q;
  logic [PW-1:0]        prod_q;
  logic signed [AW-1:0] acc_q, shifted;
  logic signed [sfvp_pkg::DATA_W-1:0] opnd;
  logic [sfvp_pkg::DATA_W-1:0]        mag;

  // One squarer is shared by U, u and v.
  always_comb begin
    if (start_i) begin
      opnd = speed_i;
    end else if (step_q == 2'd0) begin
      opnd = u_i;
    end else begin
      opnd = v_i;
    end
  end
  assign mag = opnd[sfvp_pkg::DATA_W-1] ? (~opnd + sfvp_pkg::DATA_W'(1)) : opnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i || (busy_q && step_q != 2'd2)) begin
      prod_q <= PW'(mag) * PW'(mag);
    end
    if (busy_q) begin
      if (step_q == 2'd0) begin
        acc_q <= $signed({2'b00, prod_q});
      end else begin
        acc_q <= acc_q - $signed({2'b00, prod_q});
      end
    end
  end

  // Halving plus the fraction shift, rounded toward minus infinity.
  assign shifted = acc_q >>> (sfvp_pkg::FRACTION_BITS + 1);

  always_comb begin
    if (shifted > P_MAX) begin
      pressure_o = sfvp_pkg::S32_MAX;
    end else if (shifted < P_MIN) begin
      pressure_o = sfvp_pkg::S32_MIN;
    end else begin
      pressure_o = shifted[sfvp_pkg::DATA_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

>>> sv/stream_function_velocity_pressure.sv
// A request that yields a result is taken in the idle state and walked through the line
// store reads, two runs of the bit-serial divider and the pressure unit; a divide with a
// zero coordinate difference skips the divider's bit steps. No new request is taken until
// the result is loaded into the output register, so a stalled result holds the sequencer.
// Requests that yield no result are taken in the idle state, which the sequencer keeps.
// Reset: counters return to zero and the registers to their reset values; the line stores
// are not cleared and hold no meaning until written.
`default_nettype none
module stream_function_velocity_pressure (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [sfvp_pkg::DATA_W-1:0]  cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire sfvp_pkg::in_req_t            in_req_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output sfvp_pkg::out_res_t                out_res_o
);

  localparam int CW = sfvp_pkg::COL_W;
  localparam int AW = sfvp_pkg::ADDR_W;
  localparam int KW = sfvp_pkg::COLS_W;
  localparam int RW = sfvp_pkg::ROWS_W;
  localparam int DW = sfvp_pkg::DATA_W;

  // The sequencer walks every result-bearing request through four line store reads,
  // two divisions and the pressure evaluation, one step at a time.
  typedef enum logic [12:0] {
    S_IDLE    = 13'b0_0000_0000_0001,
    S_RD0     = 13'b0_0000_0000_0010,
    S_RD1     = 13'b0_0000_0000_0100,
    S_RD2     = 13'b0_0000_0000_1000,
    S_RD3     = 13'b0_0000_0001_0000,
    S_RD4     = 13'b0_0000_0010_0000,
    S_DU_GO   = 13'b0_0000_0100_0000,
    S_DU_WAIT = 13'b0_0000_1000_0000,
    S_DV_GO   = 13'b0_0001_0000_0000,
    S_DV_WAIT = 13'b0_0010_0000_0000,
    S_PR_GO   = 13'b0_0100_0000_0000,
    S_PR_WAIT = 13'b0_1000_0000_0000,
    S_OUT     = 13'b1_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [KW-1:0]        cols_q;
  logic [RW-1:0]        rows_q;
  logic signed [DW-1:0] speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= KW'(256);
      rows_q  <= RW'(256);
      speed_q <= 32'sd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sfvp_pkg::CFG_GRID_COLUMNS: cols_q  <= cfg_data_i[KW-1:0];
        sfvp_pkg::CFG_GRID_ROWS:    rows_q  <= cfg_data_i[RW-1:0];
        sfvp_pkg::CFG_FREE_STREAM:  speed_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The column count in use is clamped to what the line stores can hold; both counts are raised to at least two.
  logic [KW-1:0] eff_cols;
  logic [RW-1:0] eff_rows, last_row;

  always_comb begin
    if (cols_q < KW'(2)) begin
      eff_cols = KW'(2);
    end else if (cols_q > KW'(sfvp_pkg::MAX_COLUMNS)) begin
      eff_cols = KW'(sfvp_pkg::MAX_COLUMNS);
    end else begin
      eff_cols = cols_q;
    end
  end
  assign eff_rows = (rows_q < RW'(2)) ? RW'(2) : rows_q;
  assign last_row = eff_rows - RW'(1);

  // Raster position counters.
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [KW-1:0] flush_q;

  // Request decode in the idle state.
  logic          in_acc, is_flush, samp_ok, flush_ok, has_res, last_col;
  logic [CW-1:0] c_sel, a_col, b_col;
  logic          cur_h, prev_h, other_h, s_h, v_h;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_flush   = (in_req_i.operation == sfvp_pkg::OP_FLUSH);
  assign c_sel      = is_flush ? flush_q[CW-1:0] : col_q;
  assign last_col   = ({1'b0, c_sel} + KW'(1)) >= eff_cols;
  assign samp_ok    = !is_flush && (row_q < eff_rows);
  assign flush_ok   = is_flush && (row_q >= eff_rows);
  assign has_res    = (samp_ok && row_q != '0) || flush_ok;

  // Row r lives in half r[0]. While row r arrives, the other half holds row r-1,
  // and for r of two or more the current half still holds row r-2.
  assign cur_h   = row_q[0];
  assign prev_h  = ~row_q[0];
  assign other_h = (row_q == RW'(1)) ? prev_h : cur_h;
  assign s_h     = last_row[0];
  assign v_h     = is_flush ? s_h : prev_h;

  // Horizontal neighbors: forward difference at the left edge, backward at the right
  // edge or beyond it, central in between.
  always_comb begin
    if (c_sel == '0) begin
      a_col = CW'(1);
      b_col = '0;
    end else if ({1'b0, c_sel} >= (eff_cols - KW'(1))) begin
      a_col = c_sel - CW'(1);
      b_col = c_sel;
    end else begin
      a_col = c_sel + CW'(1);
      b_col = c_sel - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
    end else if (in_acc) begin
      if (samp_ok) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= row_q + RW'(1);
        end else begin
          col_q <= c_sel + CW'(1);
        end
      end else if (flush_ok) begin
        if (last_col) begin
          flush_q <= '0;
          row_q   <= '0;
          col_q   <= '0;
        end else begin
          flush_q <= {1'b0, c_sel} + KW'(1);
        end
      end
    end
  end

  // Latched request context.
  logic                 item_flush_q;
  logic [AW-1:0]        addr0_q, addr_a_q, addr_b_q, addr_s_q, waddr_q;
  logic signed [DW-1:0] p1_q, y1_q, xin_q, p2_q, y2_q, pa_q, xa_q, pb_q, xb_q;
  logic signed [DW-1:0] u_q, v_q;
  logic                 fault_q, end_q;
  logic [CW-1:0]        ocol_q;
  logic [RW-1:0]        orow_q;

  // Line stores.
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  sfvp_pkg::line_word_t mem_wdata, mem_rdata;
  logic                 first_row_wr;

  assign first_row_wr = in_acc && samp_ok && (row_q == '0);
  assign mem_we       = first_row_wr || (state_q == S_RD3 && !item_flush_q);

  always_comb begin
    if (first_row_wr) begin
      mem_waddr     = {cur_h, col_q};
      mem_wdata.psi = in_req_i.stream_value;
      mem_wdata.xc  = in_req_i.x_pos;
      mem_wdata.yc  = in_req_i.y_pos;
    end else begin
      mem_waddr     = waddr_q;
      mem_wdata.psi = p1_q;
      mem_wdata.xc  = xin_q;
      mem_wdata.yc  = y1_q;
    end
  end

  always_comb begin
    unique case (state_q)
      S_RD1:   mem_raddr = addr_a_q;
      S_RD2:   mem_raddr = addr_b_q;
      S_RD3:   mem_raddr = addr_s_q;
      default: mem_raddr = addr0_q;
    endcase
  end

  sfvp_lines u_lines (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared divider: first u from the vertical difference, then v from the negated
  // horizontal difference.
  logic                 div_start, div_done, div_fault;
  logic signed [DW:0]   div_num, div_den;
  logic signed [DW-1:0] div_quo;

  assign div_start = (state_q == S_DU_GO) || (state_q == S_DV_GO);

  always_comb begin
    if (state_q == S_DU_GO) begin
      div_num = $signed({p1_q[DW-1], p1_q}) - $signed({p2_q[DW-1], p2_q});
      div_den = $signed({y1_q[DW-1], y1_q}) - $signed({y2_q[DW-1], y2_q});
    end else begin
      div_num = $signed({pb_q[DW-1], pb_q}) - $signed({pa_q[DW-1], pa_q});
      div_den = $signed({xa_q[DW-1], xa_q}) - $signed({xb_q[DW-1], xb_q});
    end
  end

  sfvp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .fault_o (div_fault)
  );

  logic                 press_start, press_done;
  logic signed [DW-1:0] press_val;

  assign press_start = (state_q == S_PR_GO);

  sfvp_press u_press (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (press_start),
    .speed_i    (speed_q),
    .u_i        (u_q),
    .v_i        (v_q),
    .done_o     (press_done),
    .pressure_o (press_val)
  );

  // Output register: it parts the result side from the input side.
  logic                out_valid_q, out_load;
  sfvp_pkg::out_res_t  out_q;

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_acc && has_res) state_d = S_RD0;
      S_RD0:     state_d = S_RD1;
      S_RD1:     state_d = S_RD2;
      S_RD2:     state_d = S_RD3;
      S_RD3:     state_d = S_RD4;
      S_RD4:     state_d = S_DU_GO;
      S_DU_GO:   state_d = S_DU_WAIT;
      S_DU_WAIT: if (div_done) state_d = S_DV_GO;
      S_DV_GO:   state_d = S_DV_WAIT;
      S_DV_WAIT: if (div_done) state_d = S_PR_GO;
      S_PR_GO:   state_d = S_PR_WAIT;
      S_PR_WAIT: if (press_done) state_d = S_OUT;
      S_OUT:     if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc && has_res) begin
      item_flush_q <= is_flush;
      addr0_q      <= is_flush ? {~s_h, c_sel} : {other_h, c_sel};
      addr_a_q     <= {v_h, a_col};
      addr_b_q     <= {v_h, b_col};
      addr_s_q     <= {s_h, c_sel};
      waddr_q      <= {cur_h, c_sel};
      p1_q         <= in_req_i.stream_value;
      y1_q         <= in_req_i.y_pos;
      xin_q        <= in_req_i.x_pos;
      ocol_q       <= c_sel;
      orow_q       <= is_flush ? last_row : (row_q - RW'(1));
      end_q        <= is_flush && last_col;
    end
    // Read data is registered and arrives in the cycle after its address.
    if (state_q == S_RD1) begin
      if (item_flush_q) begin
        p1_q <= mem_rdata.psi;
        y1_q <= mem_rdata.yc;
      end else begin
        p2_q <= mem_rdata.psi;
        y2_q <= mem_rdata.yc;
      end
    end
    if (state_q == S_RD2) begin
      pa_q <= mem_rdata.psi;
      xa_q <= mem_rdata.xc;
    end
    if (state_q == S_RD3) begin
      pb_q <= mem_rdata.psi;
      xb_q <= mem_rdata.xc;
    end
    if (state_q == S_RD4 && item_flush_q) begin
      p2_q <= mem_rdata.psi;
      y2_q <= mem_rdata.yc;
    end
    if (state_q == S_DU_WAIT && div_done) begin
      u_q     <= div_quo;
      fault_q <= div_fault;
    end
    if (state_q == S_DV_WAIT && div_done) begin
      v_q     <= div_quo;
      fault_q <= fault_q | div_fault;
    end
    if (out_load) begin
      out_q.u_vel     <= u_q;
      out_q.v_vel     <= v_q;
      out_q.pressure  <= press_val;
      out_q.cell_col  <= ocol_q;
      out_q.cell_row  <= orow_q;
      out_q.div_fault <= fault_q;
      out_q.frame_end <= end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // A result appears only when the sequencer hands it over.
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output step");

  // Line stores are written only on a first-row request or in the step that issues the last read.
  a_wr_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_IDLE || state_q == S_RD3))
    else $error("line store written while reads are pending");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DU_WAIT || state_q == S_DV_WAIT))
    else $error("divider finished outside a wait step");

  // The pressure unit finishes only while the sequencer waits for it.
  a_press_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    press_done |-> (state_q == S_PR_WAIT))
    else $error("pressure unit finished outside its wait step");

endmodule
`default_nettype wire

>>> dv/tb_stream_function_velocity_pressure.sv
`default_nettype none
module tb_stream_function_velocity_pressure;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = sfvp_pkg::DATA_W;
  localparam int MAXC = sfvp_pkg::MAX_COLUMNS;
  localparam int FB = sfvp_pkg::FRACTION_BITS;
  localparam logic signed [DW-1:0] SMAX = sfvp_pkg::S32_MAX;
  localparam logic signed [DW-1:0] SMIN = sfvp_pkg::S32_MIN;

  // Rough number of input requests for the whole run.
  localparam int TARGET_REQUESTS = 1000;
  // Settle time before a register write.
  localparam int SETTLE_CYCLES = 150;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [1:0]               cfg_index_i = '0;
  logic [DW-1:0]            cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  sfvp_pkg::in_req_t        in_req_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  sfvp_pkg::out_res_t       out_res_o;

  always #5 clk_i = ~clk_i;

  stream_function_velocity_pressure u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  // ---------------------------------------------------------------------------
  // Velocity predictor. It mirrors the two row buffers, the raster counters and
  // the three registers of the block, and works out the result that each
  // accepted request produces.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] psi_row [2][MAXC];
  logic signed [DW-1:0] xpos_row[2][MAXC];
  logic signed [DW-1:0] ypos_row[2][MAXC];
  int unsigned              col_now, row_now, flush_col;
  logic [sfvp_pkg::COLS_W-1:0] reg_columns;
  logic [sfvp_pkg::ROWS_W-1:0] reg_rows;
  logic signed [DW-1:0]     reg_speed;

  sfvp_pkg::out_res_t velocity_q[$];
  int       error_count = 0;

  function automatic int unsigned used_columns();
    if (reg_columns < 2) return 2;
    if (reg_columns > MAXC) return MAXC;
    return reg_columns;
  endfunction

  function automatic int unsigned used_rows();
    return (reg_rows < 2) ? 2 : reg_rows;
  endfunction

  function automatic logic signed [DW-1:0] clip32(longint val);
    if (val > longint'(SMAX)) return SMAX;
    if (val < longint'(SMIN)) return SMIN;
    return val[DW-1:0];
  endfunction

  // Fixed-point divide of two exact differences; a zero divisor saturates
  // toward the sign of the numerator and flags the fault.
  function automatic logic signed [DW-1:0] fx_divide(longint num, longint den,
                                                      bit negate, inout bit fault);
    if (negate) num = -num;
    if (den == 0) begin
      fault = 1'b1;
      return (num > 0) ? SMAX : ((num < 0) ? SMIN : '0);
    end
    return clip32((num * (longint'(1) << FB)) / den);
  endfunction

  function automatic longint unsigned square_mag(logic signed [DW-1:0] val);
    longint unsigned mag;
    mag = (val < 0) ? longint'(-longint'(val)) : longint'(val);
    return mag * mag;
  endfunction

  // Bernoulli pressure, floored and saturated.
  function automatic logic signed [DW-1:0] bernoulli(logic signed [DW-1:0] uu,
                                                      logic signed [DW-1:0] vv);
    longint unsigned head, loss, diff;
    head = square_mag(reg_speed);
    loss = square_mag(uu) + square_mag(vv);
    if (head >= loss) begin
      diff = (head - loss) >> (FB + 1);
      return (diff > 64'h7FFF_FFFF) ? SMAX : diff[DW-1:0];
    end
    diff = loss - head;
    diff = (diff + ((64'd1 << (FB + 1)) - 1)) >> (FB + 1);
    if (diff >= 64'h8000_0000) return SMIN;
    return 32'(-longint'(diff));
  endfunction

  // Horizontal difference along one stored row: forward at the left edge,
  // backward at the right edge, central elsewhere.
  function automatic logic signed [DW-1:0] v_from_row(int unsigned half, int unsigned c,
                                                       int unsigned cols, inout bit fault);
    int unsigned a, b;
    if (c == 0) begin
      a = 1; b = 0;
    end else if (c >= cols - 1) begin
      a = c - 1; b = c;
    end else begin
      a = c + 1; b = c - 1;
    end
    return fx_divide(longint'(psi_row[half][a]) - longint'(psi_row[half][b]),
                     longint'(xpos_row[half][a]) - longint'(xpos_row[half][b]), 1'b1, fault);
  endfunction

  function automatic bit predict_velocity(sfvp_pkg::in_req_t req,
                                          output sfvp_pkg::out_res_t res);
    int unsigned cols, rows, c, cur, other, last;
    bit fault;
    bit emitted;
    logic signed [DW-1:0] uu, vv;
    cols    = used_columns();
    rows    = used_rows();
    fault   = 1'b0;
    emitted = 1'b0;
    res     = '0;
    if (req.operation == sfvp_pkg::OP_SAMPLE) begin
      c   = col_now % MAXC;
      cur = row_now & 1;
      if (row_now >= rows) return 1'b0;
      if (row_now >= 1) begin
        // Row r-1 sits in the other half; from row 2 on, row r-2 is still here.
        other = (row_now == 1) ? (cur ^ 1) : cur;
        uu = fx_divide(longint'(req.stream_value) - longint'(psi_row[other][c]),
                       longint'(req.y_pos) - longint'(ypos_row[other][c]), 1'b0, fault);
        vv = v_from_row(cur ^ 1, c, cols, fault);
        res = '{uu, vv, bernoulli(uu, vv), c[sfvp_pkg::COL_W-1:0], 16'(row_now - 1),
                fault, 1'b0};
        emitted = 1'b1;
      end
      psi_row[cur][c]  = req.stream_value;
      xpos_row[cur][c] = req.x_pos;
      ypos_row[cur][c] = req.y_pos;
      if (c + 1 >= cols) begin
        col_now = 0;
        row_now = row_now + 1;
      end else begin
        col_now = c + 1;
      end
      return emitted;
    end
    if (row_now < rows) return 1'b0;
    last = rows - 1;
    cur  = last & 1;
    c    = flush_col % MAXC;
    uu = fx_divide(longint'(psi_row[cur ^ 1][c]) - longint'(psi_row[cur][c]),
                   longint'(ypos_row[cur ^ 1][c]) - longint'(ypos_row[cur][c]), 1'b0, fault);
    vv = v_from_row(cur, c, cols, fault);
    res = '{uu, vv, bernoulli(uu, vv), c[sfvp_pkg::COL_W-1:0], 16'(last), fault,
            (c + 1 >= cols)};
    if (c + 1 >= cols) begin
      flush_col = 0;
      row_now   = 0;
      col_now   = 0;
    end else begin
      flush_col = c + 1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Requests go out in bursts of random length separated by
  // random gaps; valid stays high across back-to-back requests.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int sent_count = 0;

  task automatic send_request(sfvp_pkg::in_req_t req, bit typed = 1'b0,
                              sfvp_pkg::out_res_t typed_res = '0);
    sfvp_pkg::out_res_t res;
    int unsigned gap;
    bit produces;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    produces = predict_velocity(req, res);
    if (produces) velocity_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  // Registers change only while the block is idle.
  task automatic wait_idle();
    while (velocity_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(sfvp_pkg::cfg_index_e idx, logic [DW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      sfvp_pkg::CFG_GRID_COLUMNS: reg_columns = val[sfvp_pkg::COLS_W-1:0];
      sfvp_pkg::CFG_GRID_ROWS:    reg_rows    = val[sfvp_pkg::ROWS_W-1:0];
      default:                    reg_speed   = val;
    endcase
  endtask

  function automatic sfvp_pkg::in_req_t mk_req(logic op, logic [31:0] psi, logic [31:0] xx,
                                               logic [31:0] yy);
    return '{op, psi, xx, yy};
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: the ready pattern switches among several stall modes, one of
  // them with no stalls at all, and every accepted result is checked.
  // ---------------------------------------------------------------------------
  int unsigned ready_mode = 0;
  int unsigned ready_tick = 0;

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    sfvp_pkg::out_res_t want;
    ready_tick <= ready_tick + 1;
    if (ready_tick % 256 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= (ready_tick % 3) != 0;
      2:       out_ready_i <= $urandom_range(0, 1);
      default: out_ready_i <= (ready_tick % 64) >= 20;
    endcase
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (velocity_q.size() == 0) begin
        report("unexpected result", 64'(out_res_o.u_vel), '0);
      end else begin
        want = velocity_q.pop_front();
        if (out_res_o.u_vel !== want.u_vel)
          report("u_vel", 64'(out_res_o.u_vel), 64'(want.u_vel));
        if (out_res_o.v_vel !== want.v_vel)
          report("v_vel", 64'(out_res_o.v_vel), 64'(want.v_vel));
        if (out_res_o.pressure !== want.pressure)
          report("pressure", 64'(out_res_o.pressure), 64'(want.pressure));
        if (out_res_o.cell_col !== want.cell_col)
          report("cell_col", 64'(out_res_o.cell_col), 64'(want.cell_col));
        if (out_res_o.cell_row !== want.cell_row)
          report("cell_row", 64'(out_res_o.cell_row), 64'(want.cell_row));
        if (out_res_o.div_fault !== want.div_fault)
          report("div_fault", 64'(out_res_o.div_fault), 64'(want.div_fault));
        if (out_res_o.frame_end !== want.frame_end)
          report("frame_end", 64'(out_res_o.frame_end), 64'(want.frame_end));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed part: a table walked by a loop. Rows with a typed result use a
  // value that follows from the arithmetic at a glance; all others fall back
  // on the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    sfvp_pkg::in_req_t  req;
    bit                 typed;
    sfvp_pkg::out_res_t res;
  } directed_row_t;

  directed_row_t directed_q[$];

  function automatic void add_row(sfvp_pkg::in_req_t req, bit typed = 1'b0,
                                  sfvp_pkg::out_res_t res = '0);
    directed_q.push_back('{req, typed, res});
  endfunction

  // One frame of random content. In the grid-like form the coordinates step
  // evenly, occasionally by zero to provoke divide faults; otherwise every
  // field is drawn over its full range.
  task automatic run_frame();
    int unsigned cols, rows;
    bit grid_like;
    logic signed [DW-1:0] x0, y0, dx, dy;
    cols = used_columns();
    rows = used_rows();
    grid_like = $urandom_range(0, 3) != 0;
    x0 = $urandom;
    y0 = $urandom;
    dx = ($urandom_range(0, 9) == 0) ? 0 : $signed($urandom_range(1, 1 << 18)) - (1 << 17);
    dy = ($urandom_range(0, 9) == 0) ? 0 : $signed($urandom_range(1, 1 << 18)) - (1 << 17);
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < cols; c++) begin
        // An early flush is ignored by the block.
        if ($urandom_range(0, 29) == 0)
          send_request(mk_req(sfvp_pkg::OP_FLUSH, $urandom, $urandom, $urandom));
        if (grid_like)
          send_request(mk_req(sfvp_pkg::OP_SAMPLE,
                              $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                              x0 + c * dx, y0 + r * dy));
        else
          send_request(mk_req(sfvp_pkg::OP_SAMPLE, $urandom, $urandom, $urandom));
      end
    end
    for (int unsigned c = 0; c < cols; c++) begin
      // A sample while the last row drains is ignored as well.
      if (c != 0 && $urandom_range(0, 19) == 0)
        send_request(mk_req(sfvp_pkg::OP_SAMPLE, $urandom, $urandom, $urandom));
      send_request(mk_req(sfvp_pkg::OP_FLUSH, $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    logic [DW-1:0] speed_pick;
    col_now = 0; row_now = 0; flush_col = 0;
    reg_columns = 256; reg_rows = 256; reg_speed = 32'sd65536;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Columns and rows below two both act as two.
    write_reg(sfvp_pkg::CFG_GRID_COLUMNS, 0);
    write_reg(sfvp_pkg::CFG_GRID_ROWS, 1);
    write_reg(sfvp_pkg::CFG_FREE_STREAM, 32'sd65536);

    // Flat field on a unit grid: zero velocity, pressure of half U squared.
    add_row(mk_req(sfvp_pkg::OP_FLUSH, 0, 0, 0));
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, 0, 0, 0));
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, 0, 32'sd65536, 0));
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, 0, 0, 32'sd65536), 1'b1,
            '{0, 0, 32768, 0, 0, 1'b0, 1'b0});
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, 0, 32'sd65536, 32'sd65536), 1'b1,
            '{0, 0, 32768, 1, 0, 1'b0, 1'b0});
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, 32'h1234_5678, 1, 1));
    add_row(mk_req(sfvp_pkg::OP_FLUSH, 0, 0, 0), 1'b1, '{0, 0, 32768, 0, 1, 1'b0, 1'b0});
    add_row(mk_req(sfvp_pkg::OP_FLUSH, 0, 0, 0), 1'b1, '{0, 0, 32768, 1, 1, 1'b0, 1'b1});
    // Extreme stream values over coincident points: every divide faults.
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, SMAX, 0, 0));
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, SMIN, 0, 0));
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, SMIN, 0, 0));
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, SMAX, 0, 0));
    add_row(mk_req(sfvp_pkg::OP_FLUSH, 0, 0, 0));
    add_row(mk_req(sfvp_pkg::OP_FLUSH, 0, 0, 0));
    // Extreme coordinates: a zero numerator over the widest divisor, and zero divisors.
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, 5, SMIN, SMAX));
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, 5, SMAX, SMIN));
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, SMAX, SMAX, SMAX));
    add_row(mk_req(sfvp_pkg::OP_SAMPLE, SMIN, SMIN, SMIN));
    add_row(mk_req(sfvp_pkg::OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(mk_req(sfvp_pkg::OP_FLUSH, 0, 0, 0));
    foreach (directed_q[i]) send_request(directed_q[i].req, directed_q[i].typed,
                                         directed_q[i].res);
    drop_valid();
    wait_idle();

    // Largest row count: a flush is ignored while rows are still due.
    write_reg(sfvp_pkg::CFG_GRID_ROWS, 16'hFFFF);
    send_request(mk_req(sfvp_pkg::OP_FLUSH, 0, 0, 0));
    drop_valid();
    wait_idle();

    // Random part: each phase rewrites the registers and runs whole frames.
    // The widest grid, with columns above the maximum, runs one frame only.
    for (int phase = 0; sent_count < TARGET_REQUESTS; phase++) begin
      if (phase == 1) begin
        write_reg(sfvp_pkg::CFG_GRID_COLUMNS, 9'h1FF);
        write_reg(sfvp_pkg::CFG_GRID_ROWS, 0);
      end else begin
        write_reg(sfvp_pkg::CFG_GRID_COLUMNS,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9));
        write_reg(sfvp_pkg::CFG_GRID_ROWS, $urandom_range(0, 6));
      end
      case ($urandom_range(0, 5))
        0:       speed_pick = SMAX;
        1:       speed_pick = SMIN;
        2:       speed_pick = 0;
        3:       speed_pick = $urandom;
        default: speed_pick = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
      write_reg(sfvp_pkg::CFG_FREE_STREAM, speed_pick);
      repeat ((phase == 1) ? 1 : $urandom_range(1, 3)) run_frame();
      drop_valid();
      wait_idle();
    end

    if (error_count == 0 && velocity_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
